>>> hw/rtl/dtpc_pkg.sv
// Shared types and constants for the point clustering block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dtpc_pkg;
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEED,
        ST_RDO,
        ST_RDP,
        ST_RDC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    localparam logic [31:0] LINK_DIST_RESET = 32'd42949673;
endpackage
`default_nettype wire

>>> hw/rtl/distance_threshold_point_clustering.sv
// Loading: one point transaction a cycle; the input is held off from the final point until
// the set's last result has gone. For N points: a seed is written and then latched, and every
// further member takes an order read, point read, latch, N reads and a three-stage compare pipe.
// Each cluster then streams one result a cycle while the output is not stalled, once the
// output has first been filled.
// Reset: asynchronous active low; clears state and counts, threshold to its default;
// memories hold no reset. Depends on dtpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module distance_threshold_point_clustering #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,  // coord_x, coord_y, coord_z
    input  wire         s_axis_tlast,  // final_point
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // member_index, group_number, group_end, pad
    output logic        m_axis_tlast,  // set_end
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = IW + 1;
    localparam int PW = 3 * COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int QW = 2 * COORD_BITS;
    localparam int SW = (QW + 2 > 32) ? QW + 2 : 32;

    dtpc_pkg::state_t state_reg, state_next;
    logic [31:0]           thr_reg, thr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;      // points held
    logic [MAX_POINTS-1:0] unas_reg, unas_next;    // unassigned mask
    logic [CW-1:0]         fill_reg, fill_next;    // entries in order list
    logic [CW-1:0]         exp_reg, exp_next;      // expand position
    logic [CW-1:0]         start_reg, start_next;  // first entry of current cluster
    logic [CW-1:0]         scan_reg, scan_next;    // read index of the scan
    logic [CW-1:0]         emit_reg, emit_next;
    logic [5:0]            grp_reg, grp_next;
    logic                  oval_reg, oval_next;    // result held on the output
    // compare pipe: read, abs difference, square, sum and compare
    logic                  v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]         i1_reg, i2_reg, i3_reg;

    // point memory, synchronous read
    logic [PW-1:0] pmem [MAX_POINTS];
    logic [PW-1:0] prd_reg;
    logic [IW-1:0] praddr;
    // cluster order memory
    logic [IW-1:0] omem [MAX_POINTS];
    logic [IW-1:0] ord_reg;
    logic [IW-1:0] oraddr;
    logic          owe;
    logic [IW-1:0] owaddr, owdata;
    logic [PW-1:0] cen_reg;                        // expanded point coordinates
    logic [COORD_BITS-1:0] adx_reg, ady_reg, adz_reg;
    logic [QW-1:0]         sqx_reg, sqy_reg, sqz_reg;

    logic accept;
    assign s_axis_tready = (state_reg == dtpc_pkg::ST_LOAD);
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = oval_reg;

    // each 16-bit field taken as a COORD_BITS-bit value
    logic [31:0]   in_x32, in_y32, in_z32;
    logic [PW-1:0] in_pt;
    assign in_x32 = {16'd0, s_axis_tdata[15:0]};
    assign in_y32 = {16'd0, s_axis_tdata[31:16]};
    assign in_z32 = {16'd0, s_axis_tdata[47:32]};
    assign in_pt  = {in_z32[COORD_BITS-1:0], in_y32[COORD_BITS-1:0], in_x32[COORD_BITS-1:0]};

    // lowest set bit of unassigned mask
    logic [IW-1:0] seed;
    always_comb
    begin
        seed = '0;
        for (int k = MAX_POINTS - 1; k >= 0; k--)
            if (unas_reg[k]) seed = IW'(k);
    end

    // absolute differences of candidate and expanded point
    logic signed [DW-1:0]  dx, dy, dz;
    logic [COORD_BITS-1:0] ax, ay, az;
    always_comb
    begin
        dx = DW'($signed(cen_reg[COORD_BITS-1:0]))
           - DW'($signed(prd_reg[COORD_BITS-1:0]));
        dy = DW'($signed(cen_reg[2*COORD_BITS-1:COORD_BITS]))
           - DW'($signed(prd_reg[2*COORD_BITS-1:COORD_BITS]));
        dz = DW'($signed(cen_reg[3*COORD_BITS-1:2*COORD_BITS]))
           - DW'($signed(prd_reg[3*COORD_BITS-1:2*COORD_BITS]));
        ax = dx[DW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ay = dy[DW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        az = dz[DW-1] ? COORD_BITS'(-dz) : dz[COORD_BITS-1:0];
    end

    // exact sum of squares against the threshold
    logic [SW-1:0] dsum;
    logic          is_link;
    assign dsum    = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
    assign is_link = dsum < SW'(thr_reg);

    logic hit;
    assign hit = v3_reg && unas_reg[i3_reg] && is_link;
    // a hit this cycle still counts for the fill level seen by scan end
    logic [CW-1:0] fill_eff;
    assign fill_eff = fill_reg + CW'(hit);

    logic scan_done, more, emit_last;
    assign scan_done = v3_reg && (i3_reg == IW'(cnt_reg - CW'(1)));
    assign more      = (exp_reg + CW'(1)) < fill_eff;
    assign emit_last = (emit_reg + CW'(1)) == fill_reg;

    // memory port control
    always_comb
    begin
        praddr = scan_reg[IW-1:0];
        oraddr = exp_reg[IW-1:0];
        owe    = 1'b0;
        owaddr = fill_reg[IW-1:0];
        owdata = i3_reg;
        case (state_reg)
            dtpc_pkg::ST_SEED:
            begin
                praddr = seed;
                owe    = 1'b1;
                owdata = seed;
            end
            dtpc_pkg::ST_RDP: praddr = ord_reg;
            dtpc_pkg::ST_SCAN: owe = hit;
            dtpc_pkg::ST_EMIT:
                oraddr = emit_reg[IW-1:0]
                       + ((m_axis_tvalid && m_axis_tready) ? IW'(1) : IW'(0));
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && cnt_reg < CW'(MAX_POINTS))
            pmem[cnt_reg[IW-1:0]] <= in_pt;
        prd_reg <= pmem[praddr];
        if (owe)
            omem[owaddr] <= owdata;
        ord_reg <= omem[oraddr];
        if (state_reg == dtpc_pkg::ST_RDC)
            cen_reg <= prd_reg;
        adx_reg <= ax;
        ady_reg <= ay;
        adz_reg <= az;
        sqx_reg <= QW'(adx_reg) * QW'(adx_reg);
        sqy_reg <= QW'(ady_reg) * QW'(ady_reg);
        sqz_reg <= QW'(adz_reg) * QW'(adz_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtpc_pkg::ST_LOAD: if (accept && s_axis_tlast) state_next = dtpc_pkg::ST_SEED;
            dtpc_pkg::ST_SEED: state_next = dtpc_pkg::ST_RDC;
            dtpc_pkg::ST_RDO:  state_next = dtpc_pkg::ST_RDP;
            dtpc_pkg::ST_RDP:  state_next = dtpc_pkg::ST_RDC;
            dtpc_pkg::ST_RDC:  state_next = dtpc_pkg::ST_SCAN;
            dtpc_pkg::ST_SCAN:
                if (scan_done)
                    state_next = more ? dtpc_pkg::ST_RDO : dtpc_pkg::ST_EMIT;
            dtpc_pkg::ST_EMIT:
                if (m_axis_tvalid && m_axis_tready && emit_last)
                    state_next = (unas_reg == '0) ? dtpc_pkg::ST_LOAD : dtpc_pkg::ST_SEED;
            default: state_next = dtpc_pkg::ST_LOAD;
        endcase
    end

    // threshold, counters, mask and output valid
    always_comb
    begin
        thr_next   = (cfg_valid && cfg_ready) ? cfg_data : thr_reg;
        cnt_next   = cnt_reg;
        unas_next  = unas_reg;
        fill_next  = fill_reg;
        exp_next   = exp_reg;
        start_next = start_reg;
        scan_next  = '0;
        emit_next  = emit_reg;
        grp_next   = grp_reg;
        oval_next  = oval_reg;
        case (state_reg)
            dtpc_pkg::ST_LOAD:
                if (accept)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                        cnt_next = cnt_reg + CW'(1);
                    if (s_axis_tlast)
                    begin
                        // every held point, the final one included unless the store is full
                        for (int k = 0; k < MAX_POINTS; k++)
                            unas_next[k] = (CW'(k) <= cnt_reg);
                        fill_next = '0;
                        grp_next  = '0;
                    end
                end
            dtpc_pkg::ST_SEED:
            begin
                unas_next[seed] = 1'b0;
                start_next = fill_reg;
                exp_next   = fill_reg;
                fill_next  = fill_reg + CW'(1);
            end
            dtpc_pkg::ST_SCAN:
            begin
                scan_next = (scan_reg < cnt_reg) ? scan_reg + CW'(1) : scan_reg;
                if (hit)
                begin
                    unas_next[i3_reg] = 1'b0;
                    fill_next = fill_eff;
                end
                if (scan_done)
                begin
                    exp_next = exp_reg + CW'(1);
                    if (!more)
                        emit_next = start_reg;
                end
            end
            dtpc_pkg::ST_EMIT:
                if (!oval_reg)
                    oval_next = 1'b1;
                else if (m_axis_tready)
                begin
                    emit_next = emit_reg + CW'(1);
                    if (emit_last)
                    begin
                        oval_next = 1'b0;
                        grp_next  = grp_reg + 6'd1;
                        if (unas_reg == '0)
                        begin
                            cnt_next = '0;
                            exp_next = '0;
                        end
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtpc_pkg::ST_LOAD;
            thr_reg   <= dtpc_pkg::LINK_DIST_RESET;
            cnt_reg   <= '0;
            unas_reg  <= '0;
            fill_reg  <= '0;
            exp_reg   <= '0;
            start_reg <= '0;
            scan_reg  <= '0;
            emit_reg  <= '0;
            grp_reg   <= '0;
            oval_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            i1_reg    <= '0;
            i2_reg    <= '0;
            i3_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
            cnt_reg   <= cnt_next;
            unas_reg  <= unas_next;
            fill_reg  <= fill_next;
            exp_reg   <= exp_next;
            start_reg <= start_next;
            scan_reg  <= scan_next;
            emit_reg  <= emit_next;
            grp_reg   <= grp_next;
            oval_reg  <= oval_next;
            v1_reg    <= (state_reg == dtpc_pkg::ST_SCAN) && (scan_reg < cnt_reg);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            i1_reg    <= scan_reg[IW-1:0];
            i2_reg    <= i1_reg;
            i3_reg    <= i2_reg;
        end
    end

    // ord_reg holds the member under emission while the output waits
    assign m_axis_tdata = {3'd0, emit_last, grp_reg, 6'(ord_reg)};
    assign m_axis_tlast = emit_last && (unas_reg == '0);

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg == dtpc_pkg::ST_EMIT)
        else $error("result outside emit");
    a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("load during emit");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_POINTS))
        else $error("order list overflow");
endmodule
`default_nettype wire
